### hw/rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, constants and transaction types of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int M_W      = 16;               // Q8.8 element
   localparam int P_W      = 32;               // element product, Q16.16
   localparam int ADJ_W    = 33;               // adjugate entry, Q16.16
   localparam int DT_W     = 49;               // determinant term
   localparam int DET_W    = 53;               // determinant, Q24.24
   localparam int TOL_W    = 48;               // tolerance register
   localparam int RES_W    = 32;               // inverse entry, Q16.16
   localparam int MAG_W    = 32;               // adjugate magnitude
   localparam int FRAC_SH  = 24;               // Q16.16 / Q24.24 alignment
   localparam int NUM_W    = 57;               // rounded dividend
   localparam int Q_BITS   = 32;               // quotient bits, one per stage
   localparam int CMP_W    = NUM_W + 28;       // wide enough for mag << 32
   localparam int N_ENT    = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);
   localparam logic [RES_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
   localparam logic [RES_W-1:0] SAT_NEG   = 32'h8000_0000;

   // One classified matrix handed from the front to the back.
   typedef struct packed {
      logic [N_ENT-1:0][ADJ_W-1:0] adj;
      logic [DET_W-1:0]            det;
      logic [DET_W-1:0]            mag;
      logic                        sing;
   } mi3_item_type;

endpackage

### hw/rtl/mi3_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_req_if
// Request channel: one 3x3 matrix of signed Q8.8 elements per transaction.
// ----------------------------------------------------------------------------
interface mi3_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

   modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                   input ready);
   modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                   output ready);
endinterface

### hw/rtl/mi3_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_rsp_if
// Response channel: inverse entries, determinant and singular flag.
// ----------------------------------------------------------------------------
interface mi3_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
   logic signed [52:0] determinant;
   logic               singular;

   modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   determinant, singular, input ready);
   modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   determinant, singular, output ready);
endinterface

### hw/rtl/mi3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Accepts matrices, forms the cofactors and determinant, classifies singular.
// ----------------------------------------------------------------------------
module mi3_front (
   input  logic                       clock,
   input  logic                       reset,
   mi3_req_if.sink                    req,
   input  logic [mi3_pkg::TOL_W-1:0]  tol,
   output logic                       item_valid,
   output mi3_pkg::mi3_item_type      item,
   input  logic                       item_ready
);
   import mi3_pkg::*;

   logic [3:0] vld_ff, vld_in;
   logic       en;

   logic signed [P_W-1:0]   prod_ff [18];
   logic signed [P_W-1:0]   prod_in [18];
   logic signed [M_W-1:0]   abc1_ff [3];
   logic signed [M_W-1:0]   abc2_ff [3];
   logic signed [ADJ_W-1:0] adj2_ff [N_ENT];
   logic signed [ADJ_W-1:0] adj2_in [N_ENT];
   logic signed [ADJ_W-1:0] adj3_ff [N_ENT];
   logic signed [DT_W-1:0]  term_ff [3];
   logic signed [DT_W-1:0]  term_in [3];
   logic signed [ADJ_W-1:0] adj4_ff [N_ENT];
   logic signed [DET_W-1:0] det_ff, det_in;
   logic [DET_W-1:0]        mag_ff, mag_in;
   logic                    sing_ff, sing_in;

   // The whole front advances unless its last stage is blocked by the queue.
   assign en        = !vld_ff[3] || item_ready;
   assign req.ready = en;
   assign vld_in    = {vld_ff[2:0], req.valid};

   // Stage 1: the eighteen element products of the 2x2 minors.
   always_comb begin
      prod_in[0]  = P_W'(req.m22) * P_W'(req.m33);
      prod_in[1]  = P_W'(req.m23) * P_W'(req.m32);
      prod_in[2]  = P_W'(req.m12) * P_W'(req.m33);
      prod_in[3]  = P_W'(req.m13) * P_W'(req.m32);
      prod_in[4]  = P_W'(req.m12) * P_W'(req.m23);
      prod_in[5]  = P_W'(req.m13) * P_W'(req.m22);
      prod_in[6]  = P_W'(req.m21) * P_W'(req.m33);
      prod_in[7]  = P_W'(req.m23) * P_W'(req.m31);
      prod_in[8]  = P_W'(req.m11) * P_W'(req.m33);
      prod_in[9]  = P_W'(req.m13) * P_W'(req.m31);
      prod_in[10] = P_W'(req.m11) * P_W'(req.m23);
      prod_in[11] = P_W'(req.m13) * P_W'(req.m21);
      prod_in[12] = P_W'(req.m21) * P_W'(req.m32);
      prod_in[13] = P_W'(req.m22) * P_W'(req.m31);
      prod_in[14] = P_W'(req.m11) * P_W'(req.m32);
      prod_in[15] = P_W'(req.m12) * P_W'(req.m31);
      prod_in[16] = P_W'(req.m11) * P_W'(req.m22);
      prod_in[17] = P_W'(req.m12) * P_W'(req.m21);
   end

   // Stage 2: signed cofactors, already laid out as the adjugate.
   always_comb begin
      for (int k = 0; k < N_ENT; k++) begin
         adj2_in[k] = ADJ_W'(prod_ff[2*k]) - ADJ_W'(prod_ff[2*k+1]);
      end
      // Entries with a negative cofactor sign swap their operands.
      adj2_in[1] = ADJ_W'(prod_ff[3])  - ADJ_W'(prod_ff[2]);
      adj2_in[3] = ADJ_W'(prod_ff[7])  - ADJ_W'(prod_ff[6]);
      adj2_in[5] = ADJ_W'(prod_ff[11]) - ADJ_W'(prod_ff[10]);
      adj2_in[7] = ADJ_W'(prod_ff[15]) - ADJ_W'(prod_ff[14]);
   end

   // Stage 3: first-row expansion terms.
   always_comb begin
      term_in[0] = DT_W'(abc2_ff[0]) * DT_W'(adj2_ff[0]);
      term_in[1] = DT_W'(abc2_ff[1]) * DT_W'(adj2_ff[3]);
      term_in[2] = DT_W'(abc2_ff[2]) * DT_W'(adj2_ff[6]);
   end

   // Stage 4: determinant, its magnitude and the singular test.
   always_comb begin
      det_in  = DET_W'(term_ff[0]) + DET_W'(term_ff[1]) + DET_W'(term_ff[2]);
      mag_in  = det_in[DET_W-1] ? DET_W'(-det_in) : DET_W'(det_in);
      sing_in = (mag_in < DET_W'(tol)) || (mag_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         abc1_ff[0] <= req.m11;
         abc1_ff[1] <= req.m12;
         abc1_ff[2] <= req.m13;
         abc2_ff    <= abc1_ff;
         adj2_ff    <= adj2_in;
         adj3_ff    <= adj2_ff;
         term_ff    <= term_in;
         adj4_ff    <= adj3_ff;
         det_ff     <= det_in;
         mag_ff     <= mag_in;
         sing_ff    <= sing_in;
      end
   end

   // Hand the classified transaction to the queue.
   always_comb begin
      item_valid = vld_ff[3];
      for (int k = 0; k < N_ENT; k++) begin
         item.adj[k] = adj4_ff[k];
      end
      item.det  = det_ff;
      item.mag  = mag_ff;
      item.sing = sing_ff;
   end

endmodule

### hw/rtl/mi3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue
// Short FIFO that decouples the front from the divider pipeline.
// ----------------------------------------------------------------------------
module mi3_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  mi3_pkg::mi3_item_type  push_item,
   output logic                   push_ready,
   output logic                   pop_valid,
   output mi3_pkg::mi3_item_type  pop_item,
   input  logic                   pop_ready
);
   import mi3_pkg::*;

   mi3_item_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill-count update.
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/mi3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// Nine pipelined restoring dividers, rounding, saturation and the response.
// ----------------------------------------------------------------------------
module mi3_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  mi3_pkg::mi3_item_type  item,
   output logic                   item_ready,
   mi3_rsp_if.source              rsp
);
   import mi3_pkg::*;

   // Stage 0 prepares the dividends, stages 1..Q_BITS each retire one bit.
   logic [Q_BITS:0]         vld_ff, vld_in;
   logic                    out_vld_ff;
   logic                    en;

   logic [NUM_W-1:0]        rem_ff [Q_BITS+1][N_ENT];
   logic [NUM_W-1:0]        rem_in [Q_BITS+1][N_ENT];
   logic [Q_BITS-1:0]       quo_ff [Q_BITS+1][N_ENT];
   logic [Q_BITS-1:0]       quo_in [Q_BITS+1][N_ENT];
   logic [N_ENT-1:0]        sat_ff [Q_BITS+1];
   logic [N_ENT-1:0]        sat_in;
   logic [N_ENT-1:0]        neg_ff [Q_BITS+1];
   logic [N_ENT-1:0]        neg_in;
   logic [DET_W-1:0]        mag_ff [Q_BITS+1];
   logic [DET_W-1:0]        det_ff [Q_BITS+1];
   logic                    sing_ff [Q_BITS+1];

   logic [RES_W-1:0]        res_ff [N_ENT];
   logic [RES_W-1:0]        res_in [N_ENT];
   logic [DET_W-1:0]        det_out_ff;
   logic                    sing_out_ff;

   // The back stalls as a whole only while a response waits at the output.
   assign en         = !out_vld_ff || rsp.ready;
   assign item_ready = en;
   assign vld_in     = {vld_ff[Q_BITS-1:0], item_valid};

   // Dividend setup and the compare-and-subtract stages of all dividers.
   always_comb begin
      logic [MAG_W-1:0] amag;
      logic [NUM_W-1:0] num;
      logic             aneg;
      logic [CMP_W-1:0] dsh;
      logic             ge;
      // Stage 0: magnitude, rounding offset and the overflow check.
      for (int k = 0; k < N_ENT; k++) begin
         aneg        = item.adj[k][ADJ_W-1];
         amag        = aneg ? MAG_W'(-item.adj[k]) : MAG_W'(item.adj[k]);
         num         = (NUM_W'(amag) << FRAC_SH) + NUM_W'(item.mag >> 1);
         rem_in[0][k] = num;
         quo_in[0][k] = '0;
         sat_in[k]   = CMP_W'(num) >= (CMP_W'(item.mag) << Q_BITS);
         neg_in[k]   = aneg != item.det[DET_W-1];
      end
      // Stages 1..Q_BITS: one compare and subtract per quotient bit.
      for (int s = 1; s <= Q_BITS; s++) begin
         for (int k = 0; k < N_ENT; k++) begin
            dsh          = CMP_W'(mag_ff[s-1]) << (Q_BITS - s);
            ge           = CMP_W'(rem_ff[s-1][k]) >= dsh;
            rem_in[s][k] = ge ? NUM_W'(CMP_W'(rem_ff[s-1][k]) - dsh)
                              : rem_ff[s-1][k];
            quo_in[s][k] = {quo_ff[s-1][k][Q_BITS-2:0], ge};
         end
      end
   end

   // Final sign, saturation and singular zeroing.
   always_comb begin
      logic [Q_BITS-1:0] q;
      for (int k = 0; k < N_ENT; k++) begin
         q = quo_ff[Q_BITS][k];
         if (sing_ff[Q_BITS]) begin
            res_in[k] = '0;
         end else if (sat_ff[Q_BITS][k]) begin
            res_in[k] = neg_ff[Q_BITS][k] ? SAT_NEG : SAT_POS;
         end else if (q == '0) begin
            res_in[k] = '0;
         end else if (neg_ff[Q_BITS][k]) begin
            res_in[k] = (q > SAT_NEG) ? SAT_NEG : RES_W'(-q);
         end else begin
            res_in[k] = (q > SAT_POS) ? SAT_POS : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[Q_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         sat_ff[0]  <= sat_in;
         neg_ff[0]  <= neg_in;
         mag_ff[0]  <= item.mag;
         det_ff[0]  <= item.det;
         sing_ff[0] <= item.sing;
         for (int s = 1; s <= Q_BITS; s++) begin
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
            sat_ff[s]  <= sat_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            mag_ff[s]  <= mag_ff[s-1];
            det_ff[s]  <= det_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
         res_ff      <= res_in;
         det_out_ff  <= det_ff[Q_BITS];
         sing_out_ff <= sing_ff[Q_BITS];
      end
   end

   // Response register drives the channel directly.
   assign rsp.valid       = out_vld_ff;
   assign rsp.r11         = res_ff[0];
   assign rsp.r12         = res_ff[1];
   assign rsp.r13         = res_ff[2];
   assign rsp.r21         = res_ff[3];
   assign rsp.r22         = res_ff[4];
   assign rsp.r23         = res_ff[5];
   assign rsp.r31         = res_ff[6];
   assign rsp.r32         = res_ff[7];
   assign rsp.r33         = res_ff[8];
   assign rsp.determinant = det_out_ff;
   assign rsp.singular    = sing_out_ff;

endmodule

### hw/rtl/matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// 3x3 matrix inverse by adjugate over determinant in fixed point.
// ----------------------------------------------------------------------------
// Each req_chan transaction carries one matrix of signed Q8.8 elements. Each
// rsp_chan transaction returns the nine inverse entries in Q16.16 (rounded
// to nearest, ties away from zero, saturated), the exact Q24.24 determinant
// and a singular flag; a singular matrix returns zero entries.
// csr_we writes csr_wdata into the singular tolerance (reset value 17);
// write it only while no transaction is in flight.
// From acceptance to rsp_chan.valid a matrix passes four front stages
// (products, cofactors, expansion terms, determinant), the queue register,
// one divider setup stage, 32 restoring-division stages at one quotient bit
// each and the response register. One matrix is accepted per cycle unless
// the receiver stalls: then the divider pipeline holds, the two-entry queue
// fills, and then the front and req_chan.ready stall. Reset empties all
// stages and the queue and restores the tolerance; there is no clearing pass.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_unit (
   input  logic                       clock,
   input  logic                       reset,
   mi3_req_if.sink                    req_chan,
   mi3_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [mi3_pkg::TOL_W-1:0]  csr_wdata
);
   import mi3_pkg::*;

   logic [TOL_W-1:0] tol_ff;
   logic             f_valid, f_ready, b_valid, b_ready;
   mi3_item_type     f_item, b_item;

   // Tolerance register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   mi3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .tol        (tol_ff),
      .item_valid (f_valid),
      .item       (f_item),
      .item_ready (f_ready)
   );

   mi3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_item  (f_item),
      .push_ready (f_ready),
      .pop_valid  (b_valid),
      .pop_item   (b_item),
      .pop_ready  (b_ready)
   );

   mi3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (b_valid),
      .item       (b_item),
      .item_ready (b_ready),
      .rsp        (rsp_chan)
   );

endmodule
